// File: rtl/core/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the plane partition update block
// word formats, configuration indexes, outcome codes and controller commands
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned CfgW   = 9;
  localparam int unsigned RatioW = 33;
  localparam int unsigned TotalW = 25;

  localparam logic [2:0] CFG_GRID_SIDE    = 3'd0;
  localparam logic [2:0] CFG_CUT_X_LO     = 3'd1;
  localparam logic [2:0] CFG_CUT_X_HI     = 3'd2;
  localparam logic [2:0] CFG_CUT_Y_LO     = 3'd3;
  localparam logic [2:0] CFG_CUT_Y_HI     = 3'd4;
  localparam logic [2:0] CFG_HEIGHT_LIMIT = 3'd5;
  localparam logic [2:0] CFG_HOLE_LEVEL   = 3'd6;
  localparam logic [2:0] CFG_HOLE_MODE    = 3'd7;

  localparam logic [1:0] OP_STEP  = 2'd0;
  localparam logic [1:0] OP_WRH   = 2'd1;
  localparam logic [1:0] OP_WRR   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] OUT_WRITTEN  = 3'd0;
  localparam logic [2:0] OUT_ACCEPTED = 3'd1;
  localparam logic [2:0] OUT_FROZEN   = 3'd2;
  localparam logic [2:0] OUT_LIMIT    = 3'd3;
  localparam logic [2:0] OUT_BLOCKED  = 3'd4;
  localparam logic [2:0] OUT_REJECTED = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  site_x;
    logic [7:0]  site_y;
    logic        direction;
    logic [31:0] uniform;
    logic [8:0]  ratio_height;
    logic [32:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [8:0]  new_height;
    logic [24:0] total_cubes;
  } out_word_t;

  typedef struct packed {
    logic [8:0] grid_side;
    logic [8:0] cut_x_lo;
    logic [8:0] cut_x_hi;
    logic [8:0] cut_y_lo;
    logic [8:0] cut_y_hi;
    logic [8:0] height_limit;
    logic [8:0] hole_level;
    logic       hole_mode;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input word, issue site read
    logic rd_a;     // issue first neighbour read
    logic rd_b;     // issue second neighbour read
    logic cap_a;    // capture first neighbour data
    logic cap_b;    // capture second neighbour data
    logic finish;   // decide, write back, load output register
  } cmd_t;

endpackage

// File: rtl/core/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl: sequencer for one item
// walks load, neighbour reads and write back, and runs the output handshake
// ----------------------------------------------------------------------------
module lgs_ctrl
  import lgs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_CAPB = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  // a new word enters once the output register is free or being drained
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_a = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b = 1'b1;
        cmd.cap_a = 1'b1;
        state_next = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_b = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/core/lgs_dpath.sv
// ----------------------------------------------------------------------------
// lgs_dpath: height memory, ratio memory, move checks and running total
// one read port per memory; neighbours come through the height port in turn
// ----------------------------------------------------------------------------
module lgs_dpath
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_MAX   = 256,
  parameter int unsigned HEIGHT_MAX = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      sweep_busy
);

  localparam int unsigned CW     = $clog2(GRID_MAX);
  localparam int unsigned AW     = 2 * CW;
  localparam int unsigned Depth  = 1 << AW;
  localparam int unsigned HStore = (HEIGHT_MAX < 511) ? HEIGHT_MAX : 511;
  localparam int unsigned RDepth = 2 * (HEIGHT_MAX + 1);
  localparam int unsigned RAW    = $clog2(RDepth);
  localparam logic [RatioW-1:0] RatioOne = {1'b1, 32'd0};

  // heights, cleared after reset by a sweep so that unwritten cells read zero
  logic [8:0]        hmem [Depth];
  logic [RatioW-1:0] rmem [RDepth];

  logic          clr_busy;
  logic [AW:0]   clr_addr;

  in_word_t   w;
  logic [8:0] hq;        // registered height read data
  logic [8:0] h_site;
  logic [8:0] nb_a;
  logic [8:0] nb_b;
  logic [RatioW-1:0] rq;
  logic [TotalW-1:0] total;
  logic [2:0] oc_q;
  logic [8:0] nh_q;

  logic [AW-1:0] h_raddr;
  logic [AW-1:0] site_addr;
  logic [8:0]    sx9, sy9, n9, mh;
  logic          in_grid, site_cut;

  // neighbour positions
  logic [8:0] ax, ay, bx, by;
  logic       a_exists, b_exists, a_cut, b_cut;
  logic       a_use, b_use;          // registered: neighbour constrains
  logic [8:0] a_val, b_val;          // registered fixed neighbour value
  logic       a_mem, b_mem;          // value comes from memory

  function automatic logic in_cut(input cfg_t c, input logic [8:0] x,
                                  input logic [8:0] y);
    in_cut = (x >= c.cut_x_lo) && (x < c.cut_x_hi) &&
             (y >= c.cut_y_lo) && (y < c.cut_y_hi);
  endfunction

  assign sx9 = {1'b0, w.site_x};
  assign sy9 = {1'b0, w.site_y};
  assign n9  = ({1'b0, cfg.grid_side} < 10'(GRID_MAX)) ? cfg.grid_side : 9'(GRID_MAX);
  assign mh  = (cfg.height_limit < 9'(HStore)) ? cfg.height_limit : 9'(HStore);
  assign in_grid  = (sx9 < n9) && (sy9 < n9);
  assign site_cut = in_cut(cfg, sx9, sy9);
  assign site_addr = {CW'(sy9), CW'(sx9)};

  // up: left and upper neighbours; down: right and lower
  always_comb begin
    if (w.direction) begin
      ax = sx9 - 9'd1; ay = sy9;
      bx = sx9;        by = sy9 - 9'd1;
      a_exists = (sx9 != 9'd0);
      b_exists = (sy9 != 9'd0);
    end else begin
      ax = sx9 + 9'd1; ay = sy9;
      bx = sx9;        by = sy9 + 9'd1;
      a_exists = (ax < n9);
      b_exists = (by < n9);
    end
    a_cut = in_cut(cfg, ax, ay);
    b_cut = in_cut(cfg, bx, by);
  end

  always_comb begin
    h_raddr = site_addr;
    if (cmd.rd_a) h_raddr = {CW'(ay), CW'(ax)};
    else if (cmd.rd_b) h_raddr = {CW'(by), CW'(bx)};
    else if (cmd.load) h_raddr = {CW'(in_word.site_y), CW'(in_word.site_x)};
  end

  // decision
  logic        dec_limit, dec_ok, dec_acc, wr_h;
  logic [8:0]  nh_move, wr_val, nh_out;
  logic [2:0]  oc;
  logic [9:0]  h_p1;
  logic [8:0]  h_m1;
  logic [8:0]  wv_sat;
  logic [8:0]  av, bv;

  assign h_p1 = {1'b0, h_site} + 10'd1;
  assign h_m1 = h_site - 9'd1;
  assign wv_sat = (w.write_value > 33'(HStore)) ? 9'(HStore) : w.write_value[8:0];
  assign av = a_mem ? nb_a : a_val;
  assign bv = b_mem ? nb_b : b_val;

  always_comb begin
    dec_limit = w.direction ? (h_p1 > {1'b0, mh})
                            : ((h_site == 9'd0) || (h_m1 > mh));
    if (w.direction)
      dec_ok = (!a_use || h_site < av) && (!b_use || h_site < bv);
    else
      dec_ok = (!a_use || h_site > av) && (!b_use || h_site > bv);
    dec_acc = {1'b0, w.uniform} < rq;
    nh_move = w.direction ? h_p1[8:0] : h_m1;
    wr_h = 1'b0;
    wr_val = wv_sat;
    nh_out = 9'd0;
    oc = OUT_WRITTEN;
    unique case (w.operation)
      OP_STEP: begin
        if (!in_grid) oc = OUT_FROZEN;
        else begin
          nh_out = h_site;
          if (site_cut) oc = OUT_FROZEN;
          else if (dec_limit) oc = OUT_LIMIT;
          else if (!dec_ok) oc = OUT_BLOCKED;
          else if (dec_acc) begin
            oc = OUT_ACCEPTED;
            nh_out = nh_move;
            wr_h = 1'b1;
            wr_val = nh_move;
          end else oc = OUT_REJECTED;
        end
      end
      OP_WRH: begin
        if (!in_grid) oc = OUT_FROZEN;
        else begin
          wr_h = 1'b1;
          nh_out = wv_sat;
        end
      end
      OP_WRR, OP_NONE: oc = OUT_WRITTEN;
      default: oc = OUT_WRITTEN;
    endcase
  end

  // ratio index from the site height, formed after the site read returns
  logic [9:0]     r_idx_step;
  logic [9:0]     r_idx_wr;
  logic [RAW-1:0] r_raddr;
  logic           r_step_ok;
  assign r_idx_step = {h_site, w.direction};
  assign r_idx_wr   = {w.ratio_height, w.direction};
  assign r_step_ok  = {1'b0, r_idx_step} < 11'(RDepth);
  assign r_raddr    = RAW'(r_idx_step);

  always_ff @(posedge clk) begin
    hq <= hmem[h_raddr];
    if (cmd.rd_a) h_site <= hq;
    if (cmd.rd_b) begin
      rq <= r_step_ok ? rmem[r_raddr] : '0;
    end
    if (cmd.cap_a) nb_a <= hq;
    if (cmd.cap_b) nb_b <= hq;
    if (cmd.load) w <= in_word;
    if (cmd.rd_a) begin
      a_use <= a_exists && !(a_cut && !cfg.hole_mode);
      b_use <= b_exists && !(b_cut && !cfg.hole_mode);
      a_mem <= !a_cut;
      b_mem <= !b_cut;
      a_val <= cfg.hole_level;
      b_val <= cfg.hole_level;
    end
    if (cmd.finish) begin
      if (w.operation == OP_WRR && {1'b0, w.ratio_height} <= 10'(HEIGHT_MAX))
        rmem[RAW'(r_idx_wr)] <= (w.write_value > RatioOne) ? RatioOne : w.write_value;
      oc_q <= oc;
      nh_q <= nh_out;
    end
  end

  // height write port shared between the clearing sweep and write back
  always_ff @(posedge clk) begin
    if (clr_busy) hmem[clr_addr[AW-1:0]] <= 9'd0;
    else if (cmd.finish && wr_h) hmem[site_addr] <= wr_val;
  end

  // total takes the old site height, read before this word writes back
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      total <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == (AW+1)'(Depth - 1)) clr_busy <= 1'b0;
      end
      if (cmd.finish && wr_h)
        total <= total - TotalW'(h_site) + TotalW'(wr_val);
    end
  end

  assign out_word = '{outcome: oc_q, new_height: nh_q, total_cubes: total};
  assign sweep_busy = clr_busy;

endmodule

// File: rtl/core/lozenge_glauber_step.sv
// ----------------------------------------------------------------------------
// lozenge_glauber_step: metropolis update of a plane partition height grid
// one step, height write or ratio write per input word
// ----------------------------------------------------------------------------
// An input word is accepted in the idle state and its result lands in the
// output register at the end of the final state: the site height is read at
// acceptance, the two neighbour heights follow one after the other through
// the single port of the height memory, the ratio memory is read alongside
// the second neighbour read, and a final state decides, writes back and
// updates the running total. The next word can be accepted in the cycle after
// the result is loaded, provided the output register is free or drained in
// that cycle; a stalled receiver delays it. After reset the height memory is
// swept to zero one cell a cycle, 65536 cells at the default GRID_MAX (the
// square of the next power of two in general), during which no word is
// accepted; configuration writes are taken at any time but should only
// change while no word is in flight.
// ----------------------------------------------------------------------------
module lozenge_glauber_step
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_MAX   = 256,
  parameter int unsigned HEIGHT_MAX = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  logic ctrl_ready;
  logic sweep_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_side    <= 9'd60;
      cfg.cut_x_lo     <= 9'd18;
      cfg.cut_x_hi     <= 9'd36;
      cfg.cut_y_lo     <= 9'd15;
      cfg.cut_y_hi     <= 9'd45;
      cfg.height_limit <= 9'd42;
      cfg.hole_level   <= 9'd0;
      cfg.hole_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIDE:    cfg.grid_side    <= cfg_data;
        CFG_CUT_X_LO:     cfg.cut_x_lo     <= cfg_data;
        CFG_CUT_X_HI:     cfg.cut_x_hi     <= cfg_data;
        CFG_CUT_Y_LO:     cfg.cut_y_lo     <= cfg_data;
        CFG_CUT_Y_HI:     cfg.cut_y_hi     <= cfg_data;
        CFG_HEIGHT_LIMIT: cfg.height_limit <= cfg_data;
        CFG_HOLE_LEVEL:   cfg.hole_level   <= cfg_data;
        CFG_HOLE_MODE:    cfg.hole_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input words are held off while the clearing sweep runs
  logic gated_valid;
  assign gated_valid = in_valid && !sweep_busy;
  assign in_ready = ctrl_ready && !sweep_busy;

  lgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gated_valid),
    .in_ready  (ctrl_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lgs_dpath #(
    .GRID_MAX   (GRID_MAX),
    .HEIGHT_MAX (HEIGHT_MAX)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_word    (in_data),
    .out_word   (out_data),
    .sweep_busy (sweep_busy)
  );

endmodule
